// ===== rtl/pwf_pkg.sv =====
package pwf_pkg;

  // Configuration register indexes
  typedef enum logic [7:0] {
    REG_REFL_LOW   = 8'd0,
    REG_REFL_HIGH  = 8'd1,
    REG_INTEN_LOW  = 8'd2,
    REG_INTEN_HIGH = 8'd3
  } cfg_reg_e;

  // Result kind codes
  typedef enum logic {
    KIND_POINT = 1'b0,
    KIND_BOX   = 1'b1
  } kind_e;

  // Register reset values
  localparam logic [15:0] REFL_LOW_RST   = 16'd50;
  localparam logic [15:0] REFL_HIGH_RST  = 16'd2000;
  localparam logic [15:0] INTEN_LOW_RST  = 16'd50;
  localparam logic [15:0] INTEN_HIGH_RST = 16'd300;

  // Depth of the queue between front and back
  localparam int unsigned Q_DEPTH = 4;

  // Classification carried with each queued item
  typedef struct packed {
    logic pass;
    logic last;
  } pwf_flags_t;

  localparam int unsigned FLAGS_BITS = $bits(pwf_flags_t);

endpackage

// ===== rtl/pwf_fifo.sv =====
module pwf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];

  // pointer and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  // a pop from an empty queue means the back end lost track
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue popped while empty");

endmodule

// ===== rtl/pwf_front.sv =====
module pwf_front #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            px_i,
  input  logic signed [31:0]            py_i,
  input  logic signed [31:0]            pz_i,
  input  logic [15:0]                   inten_i,
  input  logic [15:0]                   refl_i,
  input  logic                          frame_end_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [7:0]                    cfg_addr_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output logic signed [COORD_BITS-1:0]  ent_x_o,
  output logic signed [COORD_BITS-1:0]  ent_y_o,
  output logic signed [COORD_BITS-1:0]  ent_z_o,
  output logic [15:0]                   ent_inten_o,
  output logic [15:0]                   ent_refl_o,
  output pwf_pkg::pwf_flags_t           ent_flags_o
);

  import pwf_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [31:0]   LIM_MAX = 32'(C_MAX);
  localparam logic signed [31:0]   LIM_MIN = 32'(C_MIN);

  logic [15:0] refl_low_q, refl_high_q, inten_low_q, inten_high_q;
  logic signed [CB-1:0] zr;
  logic pass;

  // fit a 32-bit coordinate into the internal width, saturating when narrower
  function automatic logic signed [CB-1:0] fit_in(input logic signed [31:0] v);
    if (CB < 32 && v > LIM_MAX) return C_MAX;
    if (CB < 32 && v < LIM_MIN) return C_MIN;
    return CB'(v);
  endfunction

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refl_low_q   <= REFL_LOW_RST;
      refl_high_q  <= REFL_HIGH_RST;
      inten_low_q  <= INTEN_LOW_RST;
      inten_high_q <= INTEN_HIGH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_REFL_LOW:   refl_low_q   <= cfg_data_i;
        REG_REFL_HIGH:  refl_high_q  <= cfg_data_i;
        REG_INTEN_LOW:  inten_low_q  <= cfg_data_i;
        REG_INTEN_HIGH: inten_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // coordinates: saturate in, z negated with the bottom value clipped
  always_comb begin
    ent_x_o = fit_in(px_i);
    ent_y_o = fit_in(py_i);
    zr      = fit_in(pz_i);
    ent_z_o = (zr == C_MIN) ? C_MAX : -zr;
  end

  // window test
  assign pass = (refl_i > refl_low_q) && (refl_i < refl_high_q) &&
                (inten_i >= inten_low_q) && (inten_i <= inten_high_q);

  assign ent_inten_o      = inten_i;
  assign ent_refl_o       = refl_i;
  assign ent_flags_o.pass = pass;
  assign ent_flags_o.last = frame_end_i;

  // items that give no result are dropped here
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && (pass || frame_end_i);

endmodule

// ===== rtl/pwf_back.sv =====
module pwf_back #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          ent_valid_i,
  input  logic signed [COORD_BITS-1:0]  ent_x_i,
  input  logic signed [COORD_BITS-1:0]  ent_y_i,
  input  logic signed [COORD_BITS-1:0]  ent_z_i,
  input  logic [15:0]                   ent_inten_i,
  input  logic [15:0]                   ent_refl_i,
  input  pwf_pkg::pwf_flags_t           ent_flags_i,
  output logic                          ent_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic signed [31:0]            ox_o,
  output logic signed [31:0]            oy_o,
  output logic signed [31:0]            oz_o,
  output logic [15:0]                   o_inten_o,
  output logic [15:0]                   o_refl_o,
  output logic [30:0]                   half_x_o,
  output logic [30:0]                   half_y_o,
  output logic [30:0]                   half_z_o,
  output logic                          box_empty_o,
  output logic                          out_last_o
);

  import pwf_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [31:0]   O_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]   O_MIN = 32'sh8000_0000;

  // running extremes per axis: 0 x, 1 y, 2 z
  logic signed [CB-1:0] lo_q [3];
  logic signed [CB-1:0] lo_d [3];
  logic signed [CB-1:0] hi_q [3];
  logic signed [CB-1:0] hi_d [3];
  logic signed [CB-1:0] pt [3];
  logic                 any_q, any_d;
  logic                 phase_q, phase_d;   // point sent, box of same item pending

  // box arithmetic per axis
  logic signed [CB:0]   sum [3];
  logic [CB:0]          diff [3];
  logic [31:0]          ctr [3];
  logic [30:0]          half [3];

  logic load, go, emit_pt, emit_box;

  // output register
  logic        out_valid_q, out_valid_d;
  kind_e       kind_q;
  logic [31:0] ox_q, oy_q, oz_q;
  logic [15:0] inten_q, refl_q;
  logic [30:0] hx_q, hy_q, hz_q;
  logic        empty_q, last_q;

  function automatic logic [31:0] sat32(input logic signed [CB-1:0] v);
    if (v > O_MAX) return O_MAX;
    if (v < O_MIN) return O_MIN;
    return 32'(v);
  endfunction

  function automatic logic [30:0] sat31(input logic [CB-1:0] h);
    if (h > 31'h7FFF_FFFF) return 31'h7FFF_FFFF;
    return 31'(h);
  endfunction

  assign pt[0] = ent_x_i;
  assign pt[1] = ent_y_i;
  assign pt[2] = ent_z_i;

  // centre and half size, floored, from the stored extremes
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum[a]  = {lo_q[a][CB-1], lo_q[a]} + {hi_q[a][CB-1], hi_q[a]};
      diff[a] = {hi_q[a][CB-1], hi_q[a]} - {lo_q[a][CB-1], lo_q[a]};
      ctr[a]  = sat32(sum[a][CB:1]);
      half[a] = sat31(diff[a][CB:1]);
    end
  end

  // sequencing of one queued item into one or two results
  always_comb begin
    load     = !out_valid_q || !out_stall_i;
    go       = ent_valid_i && load;
    emit_pt  = go && ent_flags_i.pass && !phase_q;
    emit_box = go && !emit_pt && ent_flags_i.last;
    ent_pop_o = go && !(emit_pt && ent_flags_i.last);

    phase_d = phase_q;
    if (emit_pt && ent_flags_i.last) begin
      phase_d = 1'b1;
    end else if (emit_box) begin
      phase_d = 1'b0;
    end

    out_valid_d = load ? (emit_pt || emit_box) : out_valid_q;

    any_d = any_q;
    for (int a = 0; a < 3; a++) begin
      lo_d[a] = lo_q[a];
      hi_d[a] = hi_q[a];
    end
    if (emit_pt) begin
      any_d = 1'b1;
      for (int a = 0; a < 3; a++) begin
        if (pt[a] < lo_q[a]) lo_d[a] = pt[a];
        if (pt[a] > hi_q[a]) hi_d[a] = pt[a];
      end
    end else if (emit_box) begin
      any_d = 1'b0;
      for (int a = 0; a < 3; a++) begin
        lo_d[a] = C_MAX;
        hi_d[a] = C_MIN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      any_q       <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        lo_q[a] <= C_MAX;
        hi_q[a] <= C_MIN;
      end
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      any_q       <= any_d;
      for (int a = 0; a < 3; a++) begin
        lo_q[a] <= lo_d[a];
        hi_q[a] <= hi_d[a];
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit_pt) begin
      kind_q  <= KIND_POINT;
      ox_q    <= sat32(ent_x_i);
      oy_q    <= sat32(ent_y_i);
      oz_q    <= sat32(ent_z_i);
      inten_q <= ent_inten_i;
      refl_q  <= ent_refl_i;
      hx_q    <= '0;
      hy_q    <= '0;
      hz_q    <= '0;
      empty_q <= 1'b0;
      last_q  <= 1'b0;
    end else if (emit_box) begin
      kind_q  <= KIND_BOX;
      ox_q    <= any_q ? ctr[0] : '0;
      oy_q    <= any_q ? ctr[1] : '0;
      oz_q    <= any_q ? ctr[2] : '0;
      inten_q <= '0;
      refl_q  <= '0;
      hx_q    <= any_q ? half[0] : '0;
      hy_q    <= any_q ? half[1] : '0;
      hz_q    <= any_q ? half[2] : '0;
      empty_q <= !any_q;
      last_q  <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign ox_o        = ox_q;
  assign oy_o        = oy_q;
  assign oz_o        = oz_q;
  assign o_inten_o   = inten_q;
  assign o_refl_o    = refl_q;
  assign half_x_o    = hx_q;
  assign half_y_o    = hy_q;
  assign half_z_o    = hz_q;
  assign box_empty_o = empty_q;
  assign out_last_o  = last_q;

  // a pending box always belongs to the passing last point still at the head
  a_phase_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (ent_valid_i && ent_flags_i.pass && ent_flags_i.last))
    else $error("pending box without its item at the queue head");

  // once a point has passed, the extremes are ordered on every axis
  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q |-> (lo_q[0] <= hi_q[0] && lo_q[1] <= hi_q[1] && lo_q[2] <= hi_q[2]))
    else $error("box extremes out of order");

  // an empty box carries no geometry
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && empty_q) |->
      (last_q && hx_q == '0 && hy_q == '0 && hz_q == '0 && ox_q == '0))
    else $error("empty box with non-zero fields");

endmodule

// ===== rtl/point_window_filter_bbox.sv =====
// Point window filter with per-frame bounding box.
//
// Input channel (in_valid_i / in_stall_o): one lidar point per item, Q16.16
// coordinates, intensity, reflectivity and a frame_end mark. A point inside
// the reflectivity and intensity windows is emitted as a point result and
// widens the running box. The frame_end item also yields a box result
// (centre, half extents, empty flag), after its own point result if any.
// Output channel (out_valid_o / out_stall_i): one result per item moved.
// Configuration (cfg_valid_i / cfg_ready_o): always ready, index 0..3 picks
// the limit register, other indexes are ignored; write only while idle.
// An accepted item passes through the queue and then the output register;
// the box of a passing last point is the result right after its point result.
// The single-result output register takes one result per cycle while
// out_stall_i is low; a passing last point holds the queue head until its box is loaded.
// A four-entry queue separates classification from the box logic, so a
// stalled receiver backs up the queue before in_stall_o rises.
// Reset: limits return to their defaults, the box extremes are cleared and
// queue and output register are empty.
module point_window_filter_bbox #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] px_i,
  input  logic signed [31:0] py_i,
  input  logic signed [31:0] pz_i,
  input  logic [15:0]        inten_i,
  input  logic [15:0]        refl_i,
  input  logic               frame_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic signed [31:0] ox_o,
  output logic signed [31:0] oy_o,
  output logic signed [31:0] oz_o,
  output logic [15:0]        o_inten_o,
  output logic [15:0]        o_refl_o,
  output logic [30:0]        half_x_o,
  output logic [30:0]        half_y_o,
  output logic [30:0]        half_z_o,
  output logic               box_empty_o,
  output logic               out_last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_addr_i,
  input  logic [15:0]        cfg_data_i
);

  import pwf_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned QW = 3 * CB + 32 + FLAGS_BITS;

  logic                 q_full, q_push, q_pop, q_valid;
  logic [QW-1:0]        q_wdata, q_rdata;
  logic signed [CB-1:0] f_x, f_y, f_z, b_x, b_y, b_z;
  logic [15:0]          f_inten, f_refl, b_inten, b_refl;
  pwf_flags_t           f_flags, b_flags;

  // classification and config
  pwf_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .px_i        (px_i),
    .py_i        (py_i),
    .pz_i        (pz_i),
    .inten_i     (inten_i),
    .refl_i      (refl_i),
    .frame_end_i (frame_end_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .ent_x_o     (f_x),
    .ent_y_o     (f_y),
    .ent_z_o     (f_z),
    .ent_inten_o (f_inten),
    .ent_refl_o  (f_refl),
    .ent_flags_o (f_flags)
  );

  // queue between front and back
  assign q_wdata = {f_x, f_y, f_z, f_inten, f_refl, f_flags};
  assign {b_x, b_y, b_z, b_inten, b_refl, b_flags} = q_rdata;

  pwf_fifo #(.WIDTH(QW), .DEPTH(Q_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  // extremes, box and output register
  pwf_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (q_valid),
    .ent_x_i     (b_x),
    .ent_y_i     (b_y),
    .ent_z_i     (b_z),
    .ent_inten_i (b_inten),
    .ent_refl_i  (b_refl),
    .ent_flags_i (b_flags),
    .ent_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .ox_o        (ox_o),
    .oy_o        (oy_o),
    .oz_o        (oz_o),
    .o_inten_o   (o_inten_o),
    .o_refl_o    (o_refl_o),
    .half_x_o    (half_x_o),
    .half_y_o    (half_y_o),
    .half_z_o    (half_z_o),
    .box_empty_o (box_empty_o),
    .out_last_o  (out_last_o)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pwf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;
  localparam logic [7:0] FIRST_UNUSED_REG = REG_INTEN_HIGH + 8'd1;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] inten;
    logic [15:0] refl;
    logic        fe;
  } point_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] inten;
    logic [15:0] refl;
    logic [30:0] hx;
    logic [30:0] hy;
    logic [30:0] hz;
    logic        empty;
    logic        last;
  } result_t;

  typedef struct packed {
    point_t  pt;
    logic    typed;
    result_t res;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall_o;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;
  logic [15:0]        inten;
  logic [15:0]        refl;
  logic               frame_end;
  logic               out_valid_o;
  logic               out_stall;
  logic               kind_o;
  logic signed [31:0] ox_o;
  logic signed [31:0] oy_o;
  logic signed [31:0] oz_o;
  logic [15:0]        o_inten_o;
  logic [15:0]        o_refl_o;
  logic [30:0]        half_x_o;
  logic [30:0]        half_y_o;
  logic [30:0]        half_z_o;
  logic               box_empty_o;
  logic               out_last_o;
  logic               cfg_valid;
  logic               cfg_ready_o;
  logic [7:0]         cfg_addr;
  logic [15:0]        cfg_data;

  // Predicted limits and running box
  logic [15:0]        lim_refl_lo, lim_refl_hi, lim_inten_lo, lim_inten_hi;
  logic signed [31:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic               seen_pass;

  result_t            due_q[$];
  int                 errors = 0;
  int unsigned        cycles = 0;
  bit                 calm;
  bit                 hold_req;

  point_window_filter_bbox dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .px_i        (px),
    .py_i        (py),
    .pz_i        (pz),
    .inten_i     (inten),
    .refl_i      (refl),
    .frame_end_i (frame_end),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .kind_o      (kind_o),
    .ox_o        (ox_o),
    .oy_o        (oy_o),
    .oz_o        (oz_o),
    .o_inten_o   (o_inten_o),
    .o_refl_o    (o_refl_o),
    .half_x_o    (half_x_o),
    .half_y_o    (half_y_o),
    .half_z_o    (half_z_o),
    .box_empty_o (box_empty_o),
    .out_last_o  (out_last_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("point_window_filter_bbox test failed");
      $finish;
    end
  end

  // Idle draw shared by both sides; calm phases never idle
  function automatic int idle_draw();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 9);
  endfunction

  task automatic clear_extremes();
    lo_x = POS_MAX;
    lo_y = POS_MAX;
    lo_z = POS_MAX;
    hi_x = NEG_MAX;
    hi_y = NEG_MAX;
    hi_z = NEG_MAX;
    seen_pass = 1'b0;
  endtask

  // {centre, half}: both floored, 33-bit sum and span never overflow
  function automatic logic [62:0] axis_box(input logic [31:0] lo, input logic [31:0] hi);
    logic [32:0] sum;
    logic [32:0] span;
    sum = {lo[31], lo} + {hi[31], hi};
    span = {hi[31], hi} - {lo[31], lo};
    return {sum[32:1], span[31:1]};
  endfunction

  // Window test, point result, box widening and frame box for one item
  task automatic filter_point(input point_t p, output int n, output result_t r0,
                              output result_t r1);
    logic signed [31:0] x, y, z;
    logic [62:0] bx, by, bz;
    result_t r;
    x = p.x;
    y = p.y;
    z = (p.z == NEG_MAX) ? POS_MAX : -p.z;
    n = 0;
    r0 = '0;
    r1 = '0;
    if (p.refl > lim_refl_lo && p.refl < lim_refl_hi &&
        p.inten >= lim_inten_lo && p.inten <= lim_inten_hi) begin
      r = '0;
      r.kind = KIND_POINT;
      r.x = x;
      r.y = y;
      r.z = z;
      r.inten = p.inten;
      r.refl = p.refl;
      r0 = r;
      n = 1;
      if (x < lo_x) lo_x = x;
      if (x > hi_x) hi_x = x;
      if (y < lo_y) lo_y = y;
      if (y > hi_y) hi_y = y;
      if (z < lo_z) lo_z = z;
      if (z > hi_z) hi_z = z;
      seen_pass = 1'b1;
    end
    if (p.fe) begin
      r = '0;
      r.kind = KIND_BOX;
      r.last = 1'b1;
      if (seen_pass) begin
        bx = axis_box(lo_x, hi_x);
        by = axis_box(lo_y, hi_y);
        bz = axis_box(lo_z, hi_z);
        r.x = bx[62:31];
        r.y = by[62:31];
        r.z = bz[62:31];
        r.hx = bx[30:0];
        r.hy = by[30:0];
        r.hz = bz[30:0];
      end else begin
        r.empty = 1'b1;
      end
      if (n == 0) r0 = r;
      else r1 = r;
      n++;
      clear_extremes();
    end
  endtask

  // One item on the input channel; entered and left at a falling edge
  task automatic send_point(input point_t p, input logic typed, input result_t typed_res);
    int gap, n;
    result_t r0, r1;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    px <= p.x;
    py <= p.y;
    pz <= p.z;
    inten <= p.inten;
    refl <= p.refl;
    frame_end <= p.fe;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall_o);
    filter_point(p, n, r0, r1);
    if (typed) begin
      due_q = {due_q, typed_res};
    end else begin
      if (n > 0) due_q = {due_q, r0};
      if (n > 1) due_q = {due_q, r1};
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] addr, input logic [15:0] data);
    cfg_addr <= addr;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready_o);
    case (addr)
      REG_REFL_LOW:   lim_refl_lo = data;
      REG_REFL_HIGH:  lim_refl_hi = data;
      REG_INTEN_LOW:  lim_inten_lo = data;
      REG_INTEN_HIGH: lim_inten_hi = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_limits(input logic [15:0] rl, input logic [15:0] rh,
                            input logic [15:0] il, input logic [15:0] ih);
    write_reg(REG_REFL_LOW, rl);
    write_reg(REG_REFL_HIGH, rh);
    write_reg(REG_INTEN_LOW, il);
    write_reg(REG_INTEN_HIGH, ih);
  endtask

  // Wait for every expected result, then let in-flight items settle
  task automatic drain();
    in_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] s;
    s = $urandom();
    case ($urandom_range(0, 5))
      0, 1:    return s;
      2:       return POS_MAX - 32'($urandom_range(0, 3));
      3:       return NEG_MAX + 32'($urandom_range(0, 3));
      default: return {{12{s[19]}}, s[19:0]};
    endcase
  endfunction

  // Mostly inside the window, some on its edges, the rest anywhere
  function automatic logic [15:0] rand_window(input logic [15:0] lo, input logic [15:0] hi,
                                              input bit strict);
    int a, b;
    a = int'(lo) + (strict ? 1 : 0);
    b = int'(hi) - (strict ? 1 : 0);
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom());
      2: begin
        if ($urandom_range(0, 1) == 0) return lo + 16'($urandom_range(0, 2)) - 16'd1;
        return hi + 16'($urandom_range(0, 2)) - 16'd1;
      end
      default: begin
        if (a <= b) return 16'($urandom_range(a, b));
        return 16'($urandom());
      end
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.x = rand_coord();
    p.y = rand_coord();
    p.z = rand_coord();
    p.refl = rand_window(lim_refl_lo, lim_refl_hi, 1'b1);
    p.inten = rand_window(lim_inten_lo, lim_inten_hi, 1'b0);
    p.fe = ($urandom_range(0, 7) == 0);
    return p;
  endfunction

  function automatic row_t row(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                               input logic [15:0] i, input logic [15:0] r, input logic fe);
    row_t t;
    t = '0;
    t.pt = '{x: x, y: y, z: z, inten: i, refl: r, fe: fe};
    return t;
  endfunction

  // Receiver: random stalls per result, one long hold on request
  initial begin
    int n;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      n = idle_draw();
      if (hold_req && !hold_done) begin
        n = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid_o && !out_stall));
      @(negedge clk);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d x %h y %h z %h",
                 $time, kind_o, ox_o, oy_o, oz_o);
        errors++;
      end else begin
        want = due_q.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind_o));
        check_field("ox", want.x, ox_o);
        check_field("oy", want.y, oy_o);
        check_field("oz", want.z, oz_o);
        check_field("o_inten", 32'(want.inten), 32'(o_inten_o));
        check_field("o_refl", 32'(want.refl), 32'(o_refl_o));
        check_field("half_x", 32'(want.hx), 32'(half_x_o));
        check_field("half_y", 32'(want.hy), 32'(half_y_o));
        check_field("half_z", 32'(want.hz), 32'(half_z_o));
        check_field("box_empty", 32'(want.empty), 32'(box_empty_o));
        check_field("out_last", 32'(want.last), 32'(out_last_o));
      end
    end
  end

  initial begin
    row_t plan[$];
    row_t t;
    result_t want;
    in_valid = 1'b0;
    px = '0;
    py = '0;
    pz = '0;
    inten = '0;
    refl = '0;
    frame_end = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    lim_refl_lo = REFL_LOW_RST;
    lim_refl_hi = REFL_HIGH_RST;
    lim_inten_lo = INTEN_LOW_RST;
    lim_inten_hi = INTEN_HIGH_RST;
    clear_extremes();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, reset limits (refl 50..2000 exclusive, inten 50..300 inclusive)
    // empty frame straight after reset
    t = row(32'd0, 32'd0, 32'd0, 16'd0, 16'd100, 1'b1);
    want = '0;
    want.kind = KIND_BOX;
    want.empty = 1'b1;
    want.last = 1'b1;
    t.typed = 1'b1;
    t.res = want;
    plan = {plan, t};
    // extreme point on the window edges, z at the bottom saturates on negation
    t = row(POS_MAX, NEG_MAX, NEG_MAX, 16'd50, 16'd51, 1'b0);
    want = '0;
    want.kind = KIND_POINT;
    want.x = POS_MAX;
    want.y = NEG_MAX;
    want.z = POS_MAX;
    want.inten = 16'd50;
    want.refl = 16'd51;
    t.typed = 1'b1;
    t.res = want;
    plan = {plan, t};
    // opposite extremes closing the frame: full-range box
    plan = {plan, row(NEG_MAX, POS_MAX, POS_MAX, 16'd300, 16'd1999, 1'b1)};
    // window boundaries that reject
    plan = {plan, row(32'd1, 32'd2, 32'd3, 16'd100, 16'd50, 1'b0)};
    plan = {plan, row(32'd1, 32'd2, 32'd3, 16'd100, 16'd2000, 1'b0)};
    plan = {plan, row(32'd1, 32'd2, 32'd3, 16'd49, 16'd100, 1'b0)};
    plan = {plan, row(32'd1, 32'd2, 32'd3, 16'd301, 16'd100, 1'b0)};
    plan = {plan, row(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 16'hffff, 16'h5555, 1'b0)};
    plan = {plan, row(32'h0, 32'haaaa_aaaa, 32'h5555_5555, 16'h0, 16'hffff, 1'b0)};
    // floor rounding of centre: x spans -1..0, y spans -3..5
    plan = {plan, row(32'hffff_ffff, 32'd5, 32'd0, 16'd100, 16'd100, 1'b0)};
    plan = {plan, row(32'd0, 32'hffff_fffd, 32'd0, 16'd100, 16'd100, 1'b1)};
    // single passing point closing its own frame
    plan = {plan, row(32'h0001_0000, 32'hfffe_8000, 32'h0001_8000, 16'd200, 16'd500, 1'b1)};
    // passing point then a rejected frame end
    plan = {plan, row(32'hfffd_0000, 32'd7, 32'd9, 16'd60, 16'd60, 1'b0)};
    plan = {plan, row(32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 1'b1)};
    // x spans -3..0
    plan = {plan, row(32'hffff_fffd, 32'd1, 32'hffff_ffff, 16'd120, 16'd1000, 1'b0)};
    plan = {plan, row(32'd0, 32'd2, 32'd1, 16'd130, 16'd1001, 1'b1)};
    foreach (plan[i]) send_point(plan[i].pt, plan[i].typed, plan[i].res);
    drain();

    // Random phases, one limit setting each
    for (int ph = 1; ph <= 6; ph++) begin
      case (ph)
        1: set_limits(16'd0, 16'hffff, 16'd0, 16'hffff);
        2: begin
          lim_refl_lo = 16'($urandom_range(0, 1000));
          lim_inten_lo = 16'($urandom_range(0, 1000));
          set_limits(lim_refl_lo, lim_refl_lo + 16'($urandom_range(2, 3000)),
                     lim_inten_lo, lim_inten_lo + 16'($urandom_range(0, 3000)));
        end
        3: begin
          // crossed limits, nothing passes; stray index must be ignored
          set_limits(16'hffff, 16'd0, 16'hffff, 16'd0);
          write_reg(8'($urandom_range(FIRST_UNUSED_REG, 255)), 16'($urandom()));
        end
        4: set_limits(16'd99, 16'd101, 16'd7, 16'd7);
        5: set_limits(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
        default: set_limits(REFL_LOW_RST, REFL_HIGH_RST, INTEN_LOW_RST, INTEN_HIGH_RST);
      endcase
      calm = (ph == 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == 40) hold_req = 1'b1;
        send_point(rand_point(), 1'b0, '0);
      end
      drain();
    end

    if (errors == 0) begin
      $display("point_window_filter_bbox test passed");
    end else begin
      $display("point_window_filter_bbox test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pwf_pkg.sv
rtl/pwf_fifo.sv
rtl/pwf_front.sv
rtl/pwf_back.sv
rtl/point_window_filter_bbox.sv
tb/tb.sv
